FILE: src/fpo_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the fixed predictor order encoder.
// No dependencies; imported by every other file of the block.
package fpo_pkg;

  localparam int MAX_FRAME = 4096;
  localparam int MIN_FRAME = 4;
  localparam int ADDR_W    = $clog2(MAX_FRAME);
  localparam int LEN_W     = 13;
  localparam int POS_W     = 14;
  localparam int SMP_W     = 16;
  localparam int SUM_W     = 29;
  localparam int OUT_DW    = 24;

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic            we;
    logic [ADDR_W:0] waddr;
    sample_t         wdata;
    logic [ADDR_W:0] raddr;
  } ram_req_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_WARM = 2'd1;
  localparam logic [1:0] KIND_RES  = 2'd2;

  localparam logic CFG_LEN    = 1'b0;
  localparam logic CFG_STEREO = 1'b1;

  // binomial tap weight of sample i-t for predictor order k
  function automatic logic signed [2:0] coef(input logic [1:0] k, input logic [1:0] t);
    logic signed [2:0] c;
    c = 3'sd0;
    case ({k, t})
      4'b00_00, 4'b01_00, 4'b10_00, 4'b11_00: c = 3'sd1;
      4'b01_01: c = -3'sd1;
      4'b10_01: c = -3'sd2;
      4'b10_10: c = 3'sd1;
      4'b11_01: c = -3'sd3;
      4'b11_10: c = 3'sd3;
      4'b11_11: c = -3'sd1;
      default:  c = 3'sd0;
    endcase
    return c;
  endfunction

  function automatic logic [SMP_W:0] mag(input sample_t v);
    logic signed [SMP_W:0] e;
    e = {v[SMP_W-1], v};
    return v[SMP_W-1] ? unsigned'(-e) : unsigned'(e);
  endfunction

endpackage

FILE: src/fpo_sample_ram.sv
`timescale 1ns / 1ps
// Sample store for both channels: one write port, one registered read port.
// Depends on fpo_pkg.
module fpo_sample_ram (
  input  logic              clk,
  input  fpo_pkg::ram_req_t req,
  output fpo_pkg::sample_t  rdata
);
  import fpo_pkg::*;

  sample_t mem [0:2*MAX_FRAME-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: src/fixed_predictor_order_encoder_unit.sv
`timescale 1ns / 1ps
// Top level of the fixed predictor order encoder: sequencer, shared datapath, output register.
// Depends on fpo_pkg and fpo_sample_ram.
//
// A push word is accepted, then takes one shared-adder step per predictor order; the push that
// completes a frame then runs the order pick over both channels. A header read word needs no
// RAM read, a warm-up sample one and a residual order+1, since residuals are rebuilt from the
// sample RAM one read at a time through its single read port.
// The result sits in an output register, so the next word is taken while it waits.
// The sample RAM needs no clearing after reset.
module fixed_predictor_order_encoder_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fpo_pkg::SMP_W-1:0]  in_tdata,   // [15:0] sample
  input  logic [0:0]                 in_tuser,   // [0] op
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fpo_pkg::OUT_DW-1:0] out_tdata,  // [0] channel, [2:1] order, [18:3] value, zero
  output logic [2:0]                 out_tuser,  // [1:0] kind, [2] last_of_subframe
  output logic                       out_tlast,  // last_of_frame
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [0:0]                 cfg_index,
  input  logic [fpo_pkg::LEN_W-1:0]  cfg_data
);
  import fpo_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_RADDR = 3'd4;
  localparam logic [2:0] ST_RDATA = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]        state_r;
  logic [LEN_W-1:0]  frame_len_r;
  logic              stereo_r;
  sample_t           x_r;
  logic              ch_r;
  logic [1:0]        step_r;
  sample_t           w_r;
  sample_t           hist_r [0:1][0:2];
  sum_t              sums_r [0:7];
  logic [ADDR_W-1:0] cnt_r;
  logic              nir_r;
  logic [1:0]        ord_r [0:1];
  logic [POS_W-1:0]  pos_r;
  logic              ready_r;
  logic [1:0]        best_r;
  sum_t              bestv_r;
  logic [ADDR_W-1:0] i_r;
  logic [1:0]        kind_r;
  logic [1:0]        k_r;
  logic [1:0]        kk_r;
  logic [1:0]        t_r;
  logic              lsub_r;
  logic              lfrm_r;
  sample_t           acc_r;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic              out_ch_r;
  logic [1:0]        out_ord_r;
  sample_t           out_val_r;
  logic              out_lsub_r;
  logic              out_lfrm_r;

  logic [LEN_W-1:0]  len;
  logic [POS_W-1:0]  per;
  logic [POS_W:0]    total;
  logic              pos_end;
  logic              chs;
  logic [POS_W-1:0]  jv;
  logic [ADDR_W-1:0] iv;
  logic [1:0]        ksel;
  sample_t           hsel;
  sample_t           diff;
  sample_t           opnd;
  sum_t              cur;
  logic              in_acc;
  logic              done_cnt;
  logic              out_load;
  logic signed [SMP_W+2:0] prod;
  ram_req_t          ram_req;
  sample_t           ram_rdata;

  always_comb begin
    if (frame_len_r < LEN_W'(MIN_FRAME)) begin
      len = LEN_W'(MIN_FRAME);
    end else if (frame_len_r > LEN_W'(MAX_FRAME)) begin
      len = LEN_W'(MAX_FRAME);
    end else begin
      len = frame_len_r;
    end
  end

  assign per     = POS_W'(len) + POS_W'(1);
  assign total   = stereo_r ? {per, 1'b0} : {1'b0, per};
  assign pos_end = {1'b0, pos_r} >= total;
  assign chs     = pos_r >= per;
  assign jv      = chs ? pos_r - per : pos_r;
  assign iv      = ADDR_W'(jv - POS_W'(1));
  assign ksel    = ord_r[chs];

  always_comb begin
    case (step_r)
      2'd1:    hsel = hist_r[ch_r][0];
      2'd2:    hsel = hist_r[ch_r][1];
      2'd3:    hsel = hist_r[ch_r][2];
      default: hsel = hist_r[ch_r][0];
    endcase
  end

  assign diff     = (step_r == 2'd0) ? x_r : sample_t'(w_r - hsel);
  assign opnd     = (cnt_r >= ADDR_W'(step_r)) ? diff : x_r;
  assign cur      = sums_r[{ch_r, step_r}];
  assign done_cnt = ({1'b0, cnt_r} + (ADDR_W+1)'(1)) >= (ADDR_W+1)'(len);
  assign in_acc   = in_tvalid && in_tready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign prod     = (SMP_W+3)'(ram_rdata) * (SMP_W+3)'(coef(kk_r, t_r));

  assign ram_req.we    = (state_r == ST_ACC) && (step_r == 2'd0);
  assign ram_req.waddr = {ch_r, cnt_r};
  assign ram_req.wdata = x_r;
  assign ram_req.raddr = {ch_r, i_r - ADDR_W'(t_r)};

  fpo_sample_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-SMP_W-3){1'b0}}, out_val_r, out_ord_r, out_ch_r};
  assign out_tuser  = {out_lsub_r, out_kind_r};
  assign out_tlast  = out_lfrm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= LEN_W'(MAX_FRAME);
      stereo_r    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEN:    frame_len_r <= cfg_data;
        CFG_STEREO: stereo_r    <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      nir_r       <= 1'b0;
      pos_r       <= '0;
      ready_r     <= 1'b0;
      ord_r[0]    <= 2'd0;
      ord_r[1]    <= 2'd0;
      step_r      <= 2'd0;
      ch_r        <= 1'b0;
      for (int n = 0; n < 8; n++) begin
        sums_r[n] <= '0;
      end
      for (int c = 0; c < 2; c++) begin
        for (int h = 0; h < 3; h++) begin
          hist_r[c][h] <= '0;
        end
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            x_r    <= in_tdata;
            ch_r   <= stereo_r & nir_r;
            step_r <= 2'd0;
            if (in_tuser[0] == OP_PUSH && !ready_r) begin
              state_r <= ST_ACC;
            end else if (in_tuser[0] == OP_READ && ready_r) begin
              state_r <= ST_SETUP;
            end
          end
        end
        ST_ACC: begin
          sums_r[{ch_r, step_r}] <= cur + SUM_W'(mag(opnd));
          w_r    <= diff;
          step_r <= step_r + 2'd1;
          case (step_r)
            2'd1:    hist_r[ch_r][0] <= w_r;
            2'd2:    hist_r[ch_r][1] <= w_r;
            2'd3:    hist_r[ch_r][2] <= w_r;
            default: ;
          endcase
          if (step_r == 2'd3) begin
            if (stereo_r && !ch_r) begin
              nir_r   <= 1'b1;
              state_r <= ST_IDLE;
            end else begin
              nir_r <= 1'b0;
              if (done_cnt) begin
                cnt_r   <= '0;
                ch_r    <= 1'b0;
                state_r <= ST_PICK;
              end else begin
                cnt_r   <= cnt_r + ADDR_W'(1);
                state_r <= ST_IDLE;
              end
            end
          end
        end
        ST_PICK: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd0) begin
            best_r  <= 2'd0;
            bestv_r <= cur;
          end else if (cur < bestv_r) begin
            best_r  <= step_r;
            bestv_r <= cur;
          end
          if (step_r == 2'd3) begin
            if (ch_r && !stereo_r) begin
              ord_r[ch_r] <= 2'd0;
            end else begin
              ord_r[ch_r] <= (cur < bestv_r) ? 2'd3 : best_r;
            end
            if (ch_r) begin
              for (int n = 0; n < 8; n++) begin
                sums_r[n] <= '0;
              end
              for (int c = 0; c < 2; c++) begin
                for (int h = 0; h < 3; h++) begin
                  hist_r[c][h] <= '0;
                end
              end
              pos_r   <= '0;
              ready_r <= 1'b1;
              state_r <= ST_IDLE;
            end else begin
              ch_r <= 1'b1;
            end
          end
        end
        ST_SETUP: begin
          if (pos_end) begin
            ready_r <= 1'b0;
            pos_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            ch_r   <= chs;
            k_r    <= ksel;
            i_r    <= iv;
            t_r    <= 2'd0;
            lsub_r <= (jv == POS_W'(len));
            lfrm_r <= ({1'b0, pos_r} + (POS_W+1)'(1)) == total;
            if (jv == '0) begin
              kind_r  <= KIND_HDR;
              acc_r   <= sample_t'({9'd0, chs, ksel, 4'd0});
              state_r <= ST_OUT;
            end else if (iv < ADDR_W'(ksel)) begin
              kind_r  <= KIND_WARM;
              kk_r    <= 2'd0;
              acc_r   <= '0;
              state_r <= ST_RADDR;
            end else begin
              kind_r  <= KIND_RES;
              kk_r    <= ksel;
              acc_r   <= '0;
              state_r <= ST_RADDR;
            end
          end
        end
        ST_RADDR: begin
          state_r <= ST_RDATA;
        end
        ST_RDATA: begin
          acc_r <= acc_r + prod[SMP_W-1:0];
          if (t_r == kk_r) begin
            state_r <= ST_OUT;
          end else begin
            t_r     <= t_r + 2'd1;
            state_r <= ST_RADDR;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_kind_r  <= kind_r;
            out_ch_r    <= ch_r;
            out_ord_r   <= k_r;
            out_val_r   <= acc_r;
            out_lsub_r  <= lsub_r;
            out_lfrm_r  <= lfrm_r;
            if (lfrm_r) begin
              ready_r <= 1'b0;
              pos_r   <= '0;
            end else begin
              pos_r <= pos_r + POS_W'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/fpo_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the fixed predictor order encoder, bound to the top level.
// Depends on fpo_pkg and fixed_predictor_order_encoder_unit.
module fpo_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [0:0]                 in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [fpo_pkg::OUT_DW-1:0] out_tdata,
  input logic [2:0]                 out_tuser,
  input logic                       out_tlast
);
  import fpo_pkg::*;

  // stalled output word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("output word changed under stall");

  // a sample push never produces a word
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == OP_PUSH && !out_tvalid |=> !out_tvalid)
    else $error("push produced an output word");

  // header value agrees with channel and order fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_HDR |->
      out_tdata[6:3] == 4'd0 && out_tdata[8:7] == out_tdata[2:1]
      && out_tdata[9] == out_tdata[0] && out_tdata[18:10] == 9'd0)
    else $error("header value mismatch");

  // frame end is always a subframe end and never a header
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[2] && out_tuser[1:0] != KIND_HDR)
    else $error("frame end not on a subframe end");

endmodule

bind fixed_predictor_order_encoder_unit fpo_checker u_fpo_checker (.*);
